// ===== rtl/core/e2c_pkg.sv =====
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared types, constants and the month length table for the epoch to
// calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package e2c_pkg;

    localparam logic [9:0]  DAY_ODD       = 10'd675;       // seconds per day over 128
    localparam logic [25:0] DAY_RECIP     = 26'd50903317;  // ceil(2^35 / 675)
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [11:0] BASE_YEAR     = 12'd1970;
    localparam logic [1:0]  BASE_MOD4     = 2'd2;    // 1970 mod 4
    localparam logic [6:0]  BASE_MOD100   = 7'd70;   // 1970 mod 100
    localparam logic [8:0]  BASE_MOD400   = 9'd370;  // 1970 mod 400
    localparam logic [8:0]  DAYS_LEAP     = 9'd366;
    localparam logic [8:0]  DAYS_COMMON   = 9'd365;
    localparam logic [3:0]  MONTH_JAN     = 4'd1;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;
    localparam logic        DIV_LAST_STEP = 1'b1;

    typedef struct packed {
        logic start;      // load a new beat
        logic div_step;   // one step of the divide by seconds per day
        logic loop_step;  // one step of the year/month and h/m reduction
        logic load_out;   // copy results into the output register
    } t_cmd;

    typedef struct packed {
        logic div_last;   // current division step is the final one
        logic loop_done;  // all reductions finished
    } t_status;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            MONTH_FEB:                  len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/e2c_dp.sv =====
// ----------------------------------------------------------------------------
// e2c_dp
// Datapath: divide by seconds per day (reciprocal multiply, then
// remainder), then year/month and hour/minute reduction by repeated
// subtraction, run side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module e2c_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [31:0]      i_epoch_seconds,
    input  wire e2c_pkg::t_cmd    i_cmd,
    output e2c_pkg::t_status      o_status,
    output logic [11:0]           o_year,
    output logic [3:0]            o_month,
    output logic [4:0]            o_day_of_month,
    output logic [4:0]            o_hour,
    output logic [5:0]            o_minute,
    output logic [5:0]            o_second
);
    import e2c_pkg::*;

    logic [31:0] r_dvd;
    logic [16:0] r_rem;     // seconds of the day
    logic [15:0] r_days;
    logic        r_dphase;
    logic [11:0] r_year;
    logic [1:0]  r_mod4;
    logic [6:0]  r_mod100;
    logic [8:0]  r_mod400;
    logic [3:0]  r_month;
    logic        r_ydone;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;

    logic [50:0] recip_prod;
    logic [24:0] day_span;
    logic [9:0]  tod_hi;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        year_ge;
    logic        month_ge;
    logic        cal_done;
    logic        tod_hour;
    logic        tod_min;

    // 86400 = 128 * 675; floor(x / 675) = (x * ceil(2^35 / 675)) >> 35 for any 25-bit x
    assign recip_prod = {26'd0, r_dvd[31:7]} * {25'd0, DAY_RECIP};
    assign day_span   = {9'd0, r_days} * {15'd0, DAY_ODD};
    assign tod_hi     = 10'(r_dvd[31:7] - day_span);

    assign leap     = (r_mod4 == 2'd0) && ((r_mod100 != 7'd0) || (r_mod400 == 9'd0));
    assign ylen     = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mlen     = month_len(r_month, leap);
    assign year_ge  = r_days >= {7'd0, ylen};
    assign month_ge = (r_month != MONTH_DEC) && (r_days >= {11'd0, mlen});
    assign cal_done = r_ydone && !month_ge;
    assign tod_hour = r_rem >= {5'd0, SECS_PER_HOUR};
    assign tod_min  = r_rem >= {11'd0, SECS_PER_MIN};

    assign o_status.div_last  = (r_dphase == DIV_LAST_STEP);
    assign o_status.loop_done = cal_done && !tod_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dphase <= 1'b0;
        end else if (i_cmd.start) begin
            r_dvd    <= i_epoch_seconds;
            r_rem    <= '0;
            r_days   <= '0;
            r_dphase <= 1'b0;
            r_year   <= BASE_YEAR;
            r_mod4   <= BASE_MOD4;
            r_mod100 <= BASE_MOD100;
            r_mod400 <= BASE_MOD400;
            r_month  <= MONTH_JAN;
            r_ydone  <= 1'b0;
            r_hour   <= '0;
            r_min    <= '0;
        end else if (i_cmd.div_step) begin
            if (r_dphase == DIV_LAST_STEP) begin
                r_rem <= {tod_hi, r_dvd[6:0]};
            end else begin
                r_days <= recip_prod[50:35];
            end
            r_dphase <= ~r_dphase;
        end else if (i_cmd.loop_step) begin
            // calendar reduction
            if (!r_ydone) begin
                if (year_ge) begin
                    r_days   <= r_days - {7'd0, ylen};
                    r_year   <= r_year + 12'd1;
                    r_mod4   <= r_mod4 + 2'd1;
                    r_mod100 <= (r_mod100 == 7'd99) ? 7'd0 : r_mod100 + 7'd1;
                    r_mod400 <= (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
                end else begin
                    r_ydone <= 1'b1;
                end
            end else if (month_ge) begin
                r_days  <= r_days - {11'd0, mlen};
                r_month <= r_month + 4'd1;
            end
            // time of day reduction
            if (tod_hour) begin
                r_rem  <= r_rem - {5'd0, SECS_PER_HOUR};
                r_hour <= r_hour + 5'd1;
            end else if (tod_min) begin
                r_rem <= r_rem - {11'd0, SECS_PER_MIN};
                r_min <= r_min + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_year         <= r_year;
            o_month        <= r_month;
            o_day_of_month <= 5'(r_days + 16'd1);
            o_hour         <= r_hour;
            o_minute       <= r_min;
            o_second       <= r_rem[5:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/e2c_ctrl.sv =====
// ----------------------------------------------------------------------------
// e2c_ctrl
// Controller: sequences load, division and reduction, and owns the output
// valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module e2c_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    input  wire e2c_pkg::t_status  i_status,
    output e2c_pkg::t_cmd          o_cmd
);
    import e2c_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_LOOP = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   out_free;

    assign out_free = !r_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_LOOP;
            end
            S_LOOP: begin
                if (!i_status.loop_done) begin
                    o_cmd.loop_step = 1'b1;
                end else if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_cmd.load_out)       n_valid = 1'b1;
        else if (r_valid && i_ready) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/epoch_to_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_to_calendar
// Unix seconds to Gregorian year, month, day and time of day.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_epoch_seconds
//  result    out        o_valid / i_ready    o_year .. o_second
//
//  One beat at a time: the accepting edge loads the operand, the divide by
//  seconds per day follows (reciprocal multiply, then remainder), then the
//  reduction loop (one year per cycle, one step to close the year loop, one
//  month per cycle, with hour/minute subtraction run alongside), and the
//  output register is loaded once all reductions are done. Reset is
//  synchronous and clears only control state. A result waits in the output
//  register; the next input beat is taken while it waits, and a finished
//  conversion holds until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_to_calendar (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [11:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day_of_month,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second
);
    import e2c_pkg::*;

    t_cmd    cmd;
    t_status status;

    e2c_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    e2c_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_epoch_seconds (i_epoch_seconds),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

endmodule

`default_nettype wire

// ===== rtl/core/e2c_checker.sv =====
// ----------------------------------------------------------------------------
// e2c_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module e2c_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [11:0] o_year,
    input wire logic [3:0]  o_month,
    input wire logic [4:0]  o_day_of_month,
    input wire logic [4:0]  o_hour,
    input wire logic [5:0]  o_minute,
    input wire logic [5:0]  o_second
);

    // stalled result beat holds (year, month, day and second are checked)
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_year) && $stable(o_month)
            && $stable(o_day_of_month) && $stable(o_second))
        else $error("result beat changed while stalled");

    // busy after taking a beat: o_ready stays low while the division runs
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready ##1 !o_ready)
        else $error("input taken while converting");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_year >= 12'd1970 && o_year <= 12'd2106
            && o_month >= 4'd1 && o_month <= 4'd12 && o_day_of_month != 5'd0)
        else $error("date field out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hour < 5'd24 && o_minute < 6'd60 && o_second < 6'd60)
        else $error("time field out of range");

endmodule

bind epoch_to_calendar e2c_checker u_e2c_checker (.*);

`default_nettype wire
